### design/retrk_pkg.sv
package retrk_pkg;

    // Datapath widths.
    localparam int VALUE_WIDTH = 32;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 1;
    localparam int STEP_WIDTH  = VALUE_WIDTH - 1;
    localparam int HOLD_WIDTH  = 24;
    localparam int KIND_WIDTH  = 2;
    localparam int INDEX_WIDTH = 3;

    // Stream word layouts, padded to whole bytes.
    localparam int IN_DATA_WIDTH  = ((VALUE_WIDTH + 3 + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((VALUE_WIDTH + 2 + 7) / 8) * 8;

    // Register reset values.
    localparam logic [VALUE_WIDTH-1:0] MIN_RESET  = VALUE_WIDTH'(0);
    localparam logic [VALUE_WIDTH-1:0] MAX_RESET  = VALUE_WIDTH'(6553600);
    localparam logic [STEP_WIDTH-1:0]  STEPN_RESET = STEP_WIDTH'(65536);
    localparam logic [STEP_WIDTH-1:0]  STEPP_RESET = STEP_WIDTH'(655360);
    localparam logic [HOLD_WIDTH-1:0]  HOLD_RESET = HOLD_WIDTH'(100);

    // Item kinds; code 3 is unused and leaves the state alone.
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_TICK = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_ADD  = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_MIN_VALUE   = 3'd0,
        REG_MAX_VALUE   = 3'd1,
        REG_STEP_NORMAL = 3'd2,
        REG_STEP_PUSHED = 3'd3,
        REG_HOLD_TICKS  = 3'd4,
        REG_WRAP_MODE   = 3'd5
    } reg_index_t;

    // Configuration register file.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] min_value;
        logic [VALUE_WIDTH-1:0] max_value;
        logic [STEP_WIDTH-1:0]  step_normal;
        logic [STEP_WIDTH-1:0]  step_pushed;
        logic [HOLD_WIDTH-1:0]  hold_ticks;
        logic                   wrap_mode;
    } cfg_t;

endpackage

### design/rotary_encoder_value_tracker_top.sv
// Path: an accepted word waits in the input register, and its result is written to the result
// register when the word moves on, and is then valid on the master side.
// Throughput: one word per cycle while results are taken; the input and result registers form a
// two-stage pipeline, so a new word is taken whenever the input register is empty or moving on.
// Reset (rst_n low, asynchronous) empties both stages, loads the register defaults,
// clears value, hold counter, pushed and edge flags, and sets the last A level to one.
module rotary_encoder_value_tracker_top
    import retrk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // pin_a, pin_b, switch_level, operand[31:0]
    input  logic [KIND_WIDTH-1:0]     s_tuser,   // kind
    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0] m_tdata,   // changed, value[31:0], pushed
    // Configuration writes.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [INDEX_WIDTH-1:0]    cfg_index,
    input  logic [VALUE_WIDTH-1:0]    cfg_data
);

    cfg_t                   cfg_reg;

    logic                   in_valid_reg;
    kind_t                  in_kind_reg;
    logic                   in_a_reg;
    logic                   in_b_reg;
    logic                   in_sw_reg;
    logic [VALUE_WIDTH-1:0] in_operand_reg;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [HOLD_WIDTH-1:0]  hold_reg;
    logic [HOLD_WIDTH-1:0]  hold_next;
    logic                   press_reg;
    logic                   press_next;
    logic                   pending_reg;
    logic                   pending_next;
    logic                   last_a_reg;
    logic                   last_a_next;
    logic                   changed_next;

    logic                   out_valid_reg;
    logic                   out_changed_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_pushed_reg;

    logic                   advance;
    logic                   apply_range;
    logic signed [SUM_WIDTH-1:0] cand;
    logic signed [SUM_WIDTH-1:0] min_ext;
    logic signed [SUM_WIDTH-1:0] max_ext;
    logic signed [SUM_WIDTH-1:0] lo;
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] cur_ext;
    logic signed [SUM_WIDTH-1:0] opd_ext;
    logic signed [SUM_WIDTH-1:0] step_ext;
    logic signed [SUM_WIDTH-1:0] ranged;

    // Handshakes.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_WIDTH - VALUE_WIDTH - 2){1'b0}},
                        out_pushed_reg, out_value_reg, out_changed_reg};

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value   <= MIN_RESET;
            cfg_reg.max_value   <= MAX_RESET;
            cfg_reg.step_normal <= STEPN_RESET;
            cfg_reg.step_pushed <= STEPP_RESET;
            cfg_reg.hold_ticks  <= HOLD_RESET;
            cfg_reg.wrap_mode   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_VALUE:   cfg_reg.min_value   <= cfg_data;
                REG_MAX_VALUE:   cfg_reg.max_value   <= cfg_data;
                REG_STEP_NORMAL: cfg_reg.step_normal <= cfg_data[STEP_WIDTH-1:0];
                REG_STEP_PUSHED: cfg_reg.step_pushed <= cfg_data[STEP_WIDTH-1:0];
                REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= cfg_data[HOLD_WIDTH-1:0];
                REG_WRAP_MODE:   cfg_reg.wrap_mode   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg    <= kind_t'(s_tuser);
            in_a_reg       <= s_tdata[0];
            in_b_reg       <= s_tdata[1];
            in_sw_reg      <= s_tdata[2];
            in_operand_reg <= s_tdata[VALUE_WIDTH+2:3];
        end
    end

    // Ordered bounds, one bit wider than the value.
    assign min_ext = SUM_WIDTH'(signed'(cfg_reg.min_value));
    assign max_ext = SUM_WIDTH'(signed'(cfg_reg.max_value));
    assign lo      = (min_ext < max_ext) ? min_ext : max_ext;
    assign hi      = (min_ext < max_ext) ? max_ext : min_ext;
    assign cur_ext = SUM_WIDTH'(signed'(value_reg));
    assign opd_ext = SUM_WIDTH'(signed'(in_operand_reg));
    assign step_ext = press_next
                    ? signed'({{(SUM_WIDTH - STEP_WIDTH){1'b0}}, cfg_reg.step_pushed})
                    : signed'({{(SUM_WIDTH - STEP_WIDTH){1'b0}}, cfg_reg.step_normal});

    // Switch, edge and candidate value for the word in the input register.
    always_comb
    begin
        hold_next    = hold_reg;
        press_next   = press_reg;
        pending_next = pending_reg;
        last_a_next  = last_a_reg;
        changed_next = 1'b0;
        apply_range  = 1'b0;
        cand         = cur_ext;
        unique case (in_kind_reg)
            KIND_TICK:
            begin
                if (!in_sw_reg)
                begin
                    hold_next  = cfg_reg.hold_ticks;
                    press_next = 1'b1;
                end
                else if ((hold_reg != '0) && press_reg)
                begin
                    hold_next = hold_reg - HOLD_WIDTH'(1);
                end
                else
                begin
                    press_next = 1'b0;
                end
                if (pending_reg)
                begin
                    if (in_a_reg && last_a_reg)
                    begin
                        apply_range  = 1'b1;
                        changed_next = 1'b1;
                        cand = in_b_reg ? (cur_ext + step_ext) : (cur_ext - step_ext);
                    end
                    pending_next = 1'b0;
                end
                else if (in_a_reg != last_a_reg)
                begin
                    pending_next = 1'b1;
                end
                last_a_next = in_a_reg;
            end
            KIND_LOAD:
            begin
                apply_range = 1'b1;
                cand        = opd_ext;
            end
            KIND_ADD:
            begin
                apply_range = 1'b1;
                cand        = cur_ext + opd_ext;
            end
            default: ;
        endcase
    end

    // Clamp or wrap to the bounds.
    always_comb
    begin
        priority if (cand < lo)
        begin
            ranged = cfg_reg.wrap_mode ? hi : lo;
        end
        else if (cand > hi)
        begin
            ranged = cfg_reg.wrap_mode ? lo : hi;
        end
        else
        begin
            ranged = cand;
        end
        value_next = apply_range ? ranged[VALUE_WIDTH-1:0] : value_reg;
    end

    // Tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg   <= '0;
            hold_reg    <= '0;
            press_reg   <= 1'b0;
            pending_reg <= 1'b0;
            last_a_reg  <= 1'b1;
        end
        else if (advance)
        begin
            value_reg   <= value_next;
            hold_reg    <= hold_next;
            press_reg   <= press_next;
            pending_reg <= pending_next;
            last_a_reg  <= last_a_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_changed_reg <= changed_next;
            out_value_reg   <= value_next;
            out_pushed_reg  <= press_next;
        end
    end

endmodule

### design/retrk_checker.sv
module retrk_props
    import retrk_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_DATA_WIDTH-1:0] m_tdata,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side stalls only when both stages are full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the result register");

    // No result word right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result word valid right after reset");

    // A result word needs an input word accepted first, so none shows in the next cycle either.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) ##1 1'b1 |-> !m_tvalid)
        else $error("result word appeared too early after reset");

    // Configuration writes are never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind rotary_encoder_value_tracker_top retrk_props u_retrk_props (.*);

### tb/sv/retrk_checker.sv
module retrk_checker
    import retrk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // pin_a, pin_b, switch_level, operand[31:0]
    input  logic [KIND_WIDTH-1:0]     s_tuser,   // kind
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_DATA_WIDTH-1:0] m_tdata,   // changed, value[31:0], pushed
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [INDEX_WIDTH-1:0]    cfg_index,
    input  logic [VALUE_WIDTH-1:0]    cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        words_checked,
    output int                        detents_seen
);

    // One result word as the block reports it.
    typedef struct packed {
        logic                   changed;
        logic [VALUE_WIDTH-1:0] value;
        logic                   pushed;
    } reading_t;

    // Register copy and tracker state of the predictor.
    cfg_t                          regs;
    logic signed [VALUE_WIDTH-1:0] cur_value;
    logic [HOLD_WIDTH-1:0]         hold_left;
    logic                          pushed_flag;
    logic                          edge_armed;
    logic                          prev_a;

    reading_t expected_readings[$];
    reading_t got;
    reading_t want;
    int       err_n;
    int       checked_n;
    int       detent_n;

    // Fit a wide sum into the ordered range, clamping or wrapping.
    function automatic logic signed [VALUE_WIDTH-1:0] bound_value(input longint sum);
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint v;
        a  = longint'(signed'(regs.min_value));
        b  = longint'(signed'(regs.max_value));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        v  = sum;
        if (v < lo)
            v = regs.wrap_mode ? hi : lo;
        if (v > hi)
            v = regs.wrap_mode ? lo : hi;
        return v[VALUE_WIDTH-1:0];
    endfunction

    // Advance the tracker by one word and work out the result it reports.
    task automatic track_item(input logic [KIND_WIDTH-1:0] kind, input logic a, input logic b,
                              input logic sw, input logic [VALUE_WIDTH-1:0] operand,
                              output reading_t res);
        logic   moved;
        longint step_amt;
        longint sum;
        moved = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                // Switch: a press reloads the hold time, release counts it down.
                if (!sw)
                begin
                    hold_left   = regs.hold_ticks;
                    pushed_flag = 1'b1;
                end
                else if (hold_left != '0 && pushed_flag)
                    hold_left = hold_left - HOLD_WIDTH'(1);
                else
                    pushed_flag = 1'b0;
                // Encoder: an armed edge moves the value if A is still high.
                if (edge_armed)
                begin
                    if (a == prev_a && a)
                    begin
                        step_amt = pushed_flag ? longint'(regs.step_pushed)
                                               : longint'(regs.step_normal);
                        sum = b ? longint'(cur_value) + step_amt
                                : longint'(cur_value) - step_amt;
                        cur_value = bound_value(sum);
                        moved = 1'b1;
                    end
                    edge_armed = 1'b0;
                end
                else if (a != prev_a)
                    edge_armed = 1'b1;
                prev_a = a;
            end
            KIND_LOAD:
                cur_value = bound_value(longint'(signed'(operand)));
            KIND_ADD:
                cur_value = bound_value(longint'(cur_value) + longint'(signed'(operand)));
            default:
                ;
        endcase
        res.changed = moved;
        res.value   = cur_value;
        res.pushed  = pushed_flag;
    endtask

    // Watch all three channels; results are checked before new words are predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.min_value   = MIN_RESET;
            regs.max_value   = MAX_RESET;
            regs.step_normal = STEPN_RESET;
            regs.step_pushed = STEPP_RESET;
            regs.hold_ticks  = HOLD_RESET;
            regs.wrap_mode   = 1'b0;
            cur_value   = '0;
            hold_left   = '0;
            pushed_flag = 1'b0;
            edge_armed  = 1'b0;
            prev_a      = 1'b1;
            expected_readings.delete();
            err_n     = 0;
            checked_n = 0;
            detent_n  = 0;
            mismatches    <= 0;
            outstanding   <= 0;
            words_checked <= 0;
            detents_seen  <= 0;
        end
        else
        begin
            // Register writes, masked to each register's width.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_VALUE:   regs.min_value   = cfg_data;
                    REG_MAX_VALUE:   regs.max_value   = cfg_data;
                    REG_STEP_NORMAL: regs.step_normal = cfg_data[STEP_WIDTH-1:0];
                    REG_STEP_PUSHED: regs.step_pushed = cfg_data[STEP_WIDTH-1:0];
                    REG_HOLD_TICKS:  regs.hold_ticks  = cfg_data[HOLD_WIDTH-1:0];
                    REG_WRAP_MODE:   regs.wrap_mode   = cfg_data[0];
                    default:         ;
                endcase
            end

            // Compare each result word with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got.changed = m_tdata[0];
                got.value   = m_tdata[VALUE_WIDTH:1];
                got.pushed  = m_tdata[VALUE_WIDTH+1];
                checked_n++;
                if (expected_readings.size() == 0)
                begin
                    err_n++;
                    if (err_n <= 10)
                        $display("Unexpected result word: changed=%0b value=%h pushed=%0b",
                                 got.changed, got.value, got.pushed);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got !== want)
                    begin
                        err_n++;
                        if (err_n <= 10)
                        begin
                            $display("Mismatch at result %0d: expected changed=%0b value=%h pushed=%0b",
                                     checked_n, want.changed, want.value, want.pushed);
                            $display("    got changed=%0b value=%h pushed=%0b",
                                     got.changed, got.value, got.pushed);
                        end
                    end
                end
            end

            // Predict the result of each accepted input word.
            if (s_tvalid && s_tready)
            begin
                track_item(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2],
                           s_tdata[VALUE_WIDTH+2:3], want);
                expected_readings.push_back(want);
                if (want.changed)
                    detent_n++;
            end

            mismatches    <= err_n;
            outstanding   <= expected_readings.size();
            words_checked <= checked_n;
            detents_seen  <= detent_n;
        end
    end

endmodule

### tb/sv/tb.sv
module tb;
    import retrk_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 88;
    localparam int PAD_WIDTH     = IN_DATA_WIDTH - VALUE_WIDTH - 3;
    localparam logic [KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;
    localparam logic [VALUE_WIDTH-1:0] ONE    = 32'h0001_0000;
    localparam logic [VALUE_WIDTH-1:0] MAXPOS = 32'h7FFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] MAXNEG = 32'h8000_0000;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_WIDTH-1:0]  s_tdata;   // pin_a, pin_b, switch_level, operand[31:0]
    logic [KIND_WIDTH-1:0]     s_tuser;   // kind
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;   // changed, value[31:0], pushed
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [INDEX_WIDTH-1:0]    cfg_index;
    logic [VALUE_WIDTH-1:0]    cfg_data;

    int mismatches;
    int outstanding;
    int words_checked;
    int detents_seen;
    int cycles;
    int src_idle_pct;
    int sink_stall_pct;

    // Encoder and switch levels carried between random words.
    logic enc_a;
    logic sw_held;

    rotary_encoder_value_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    retrk_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .detents_seen  (detents_seen)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver side: stall at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one input word and wait until it is taken.
    task automatic send_word(input logic [KIND_WIDTH-1:0] kind, input logic a, input logic b,
                             input logic sw, input logic [VALUE_WIDTH-1:0] operand);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {PAD_WIDTH'(0), operand, sw, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic tick(input logic a, input logic b, input logic sw);
        send_word(KIND_TICK, a, b, sw, $urandom);
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one register write and wait for it; valid stays high for the next one.
    task automatic put_reg(input reg_index_t idx, input logic [VALUE_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] lo_bound, input logic [31:0] hi_bound,
                                input logic [31:0] step_n, input logic [31:0] step_p,
                                input logic [31:0] hold, input logic [31:0] wrap);
        put_reg(REG_MIN_VALUE, lo_bound);
        put_reg(REG_MAX_VALUE, hi_bound);
        put_reg(REG_STEP_NORMAL, step_n);
        put_reg(REG_STEP_PUSHED, step_p);
        put_reg(REG_HOLD_TICKS, hold);
        put_reg(REG_WRAP_MODE, wrap);
        cfg_valid <= 1'b0;
    endtask

    // Operands mix full random words, small signed Q16.16 values and the extremes.
    function automatic logic [VALUE_WIDTH-1:0] pick_operand();
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return VALUE_WIDTH'(($urandom_range(40) - 20) * 65536);
            default: return $urandom_range(1) ? MAXPOS : MAXNEG;
        endcase
    endfunction

    // Mostly encoder ticks that follow a slowly changing A level and switch.
    task automatic random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            send_word(KIND_LOAD, 1'($urandom), 1'($urandom), 1'($urandom), pick_operand());
        else if (roll < 16)
            send_word(KIND_ADD, 1'($urandom), 1'($urandom), 1'($urandom), pick_operand());
        else if (roll < 20)
            send_word(KIND_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
        else
        begin
            if ($urandom_range(99) < 35)
                enc_a = ~enc_a;
            if (sw_held)
                sw_held = ($urandom_range(99) >= 30);
            else
                sw_held = ($urandom_range(99) < 8);
            if ($urandom_range(99) < 5)
                tick(1'($urandom), 1'($urandom), 1'($urandom));
            else
                tick(enc_a, 1'($urandom), ~sw_held);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_TICK;
        cfg_valid      = 1'b0;
        cfg_index      = REG_MIN_VALUE;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        enc_a          = 1'b1;
        sw_held        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the reset register values.
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b1, 1'b1);            // armed edge but A low: no move
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);            // detent up
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b1, 1'b0, 1'b1);
        tick(1'b1, 1'b0, 1'b1);            // detent down to the lower bound
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b1, 1'b0, 1'b1);
        tick(1'b1, 1'b0, 1'b1);            // clamps at the lower bound
        tick(1'b0, 1'b1, 1'b0);            // press
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);            // pushed step up
        send_word(KIND_LOAD, 1'b1, 1'b0, 1'b0, MAXPOS);
        send_word(KIND_LOAD, 1'b0, 1'b1, 1'b1, MAXNEG);
        send_word(KIND_LOAD, 1'b1, 1'b1, 1'b0, 32'd50 * ONE);
        send_word(KIND_ADD, 1'b0, 1'b0, 1'b1, MAXPOS);
        send_word(KIND_ADD, 1'b1, 1'b1, 1'b1, MAXNEG);
        send_word(KIND_ADD, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(KIND_UNUSED, 1'b1, 1'b1, 1'b0, $urandom);

        // Random phases, each under its own register settings and idling mix.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: program_regs(32'd0, 32'd100 * ONE, ONE, 32'd10 * ONE, 32'd3, 32'd0);
                1: program_regs(-32'sd5 * ONE, 32'd5 * ONE, 32'd3 * ONE, 32'd7 * ONE,
                                32'd0, 32'd1);
                2: program_regs(MAXNEG, MAXPOS, MAXPOS, MAXPOS, 32'h00FF_FFFF, 32'd0);
                3: program_regs(MAXNEG, MAXPOS, 32'd0, 32'd1, 32'd2, 32'd1);
                4: program_regs(32'd10 * ONE, -32'sd10 * ONE, $urandom_range(8) * ONE,
                                $urandom, 32'd1, $urandom);
                5: program_regs(32'd7 * ONE, 32'd7 * ONE, ONE, ONE, 32'd5, 32'd1);
                6: program_regs(-($urandom_range(30) * ONE), $urandom_range(30) * ONE,
                                $urandom_range(4 * 65536), $urandom_range(16 * 65536),
                                $urandom_range(20), $urandom);
                default: program_regs($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
            endcase
            case (p % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 86;
                end
                default:
                begin
                    src_idle_pct   = 19;
                    sink_stall_pct = 19;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_word();
        end

        wait_drained();
        $display("Checked %0d result words over %0d register settings; %0d were detent moves.",
                 words_checked, PHASES + 1, detents_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
design/retrk_pkg.sv
design/rotary_encoder_value_tracker_top.sv
design/retrk_checker.sv
tb/sv/retrk_checker.sv
tb/sv/tb.sv
